>>> rtl/mhpt_pkg.sv
`default_nettype none
package mhpt_pkg;
  localparam int HEAP_DEPTH = 1024;
  localparam int KEY_WIDTH  = 32;
  localparam int IDX_W      = $clog2(HEAP_DEPTH);
  localparam int CNT_W      = IDX_W + 1;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_DELETE = 2'd1;
  localparam logic [1:0] OP_SEARCH = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_EMPTY    = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  typedef logic [KEY_WIDTH-1:0] key_t;
  typedef logic [IDX_W-1:0]     idx_t;
  typedef logic [CNT_W-1:0]     cnt_t;

  typedef struct packed {
    logic we;
    idx_t waddr;
    key_t wdata;
    logic re;
    idx_t raddr;
  } mem_req_t;
endpackage
`default_nettype wire

>>> rtl/mhpt_ram.sv
`default_nettype none
module mhpt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule
`default_nettype wire

>>> rtl/mhpt_ctrl.sv
`default_nettype none
module mhpt_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            start,
  input  wire logic [1:0]      op,
  input  wire mhpt_pkg::key_t  key,
  output logic                 busy,
  output logic                 done,
  output logic [1:0]           res_status,
  output mhpt_pkg::idx_t       res_index,
  output mhpt_pkg::cnt_t       res_count,
  output mhpt_pkg::key_t       res_top,
  output mhpt_pkg::mem_req_t   mreq,
  input  wire mhpt_pkg::key_t  rdata
);
  import mhpt_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_SCAN   = 4'd1;
  localparam logic [3:0] S_SCANW  = 4'd2;
  localparam logic [3:0] S_LASTW  = 4'd3;
  localparam logic [3:0] S_SUP_W  = 4'd4;
  localparam logic [3:0] S_SUP    = 4'd5;
  localparam logic [3:0] S_SDL_W  = 4'd6;
  localparam logic [3:0] S_SDR_W  = 4'd7;
  localparam logic [3:0] S_SDR    = 4'd8;
  localparam logic [3:0] S_TOP_W  = 4'd9;
  localparam logic [3:0] S_TOP    = 4'd10;
  localparam logic [3:0] S_DONE   = 4'd11;

  logic [3:0] state_r, state_nxt;
  cnt_t count_r, count_nxt;
  logic [1:0] op_r, op_nxt;
  key_t key_r, key_nxt;       // biased search key / value being sifted
  cnt_t pos_r, pos_nxt;       // current position (wide to hold count)
  key_t lval_r, lval_nxt;     // left child value
  logic [1:0] st_r, st_nxt;
  idx_t idx_r, idx_nxt;
  key_t top_r, top_nxt;
  logic did_down_r, did_down_nxt;

  localparam key_t SIGN = {1'b1, {(KEY_WIDTH-1){1'b0}}};

  cnt_t lch, rch, par;
  assign lch = cnt_t'({pos_r[CNT_W-2:0], 1'b1});
  assign rch = cnt_t'({pos_r[CNT_W-2:0], 1'b0}) + cnt_t'(2);
  assign par = (pos_r - cnt_t'(1)) >> 1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
    op_r <= op_nxt; key_r <= key_nxt; pos_r <= pos_nxt; lval_r <= lval_nxt;
    st_r <= st_nxt; idx_r <= idx_nxt; top_r <= top_nxt;
    did_down_r <= did_down_nxt;
  end

  always_comb begin
    state_nxt = state_r; count_nxt = count_r; op_nxt = op_r; key_nxt = key_r;
    pos_nxt = pos_r; lval_nxt = lval_r; st_nxt = st_r; idx_nxt = idx_r;
    top_nxt = top_r; did_down_nxt = did_down_r;
    mreq = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          op_nxt = op;
          key_nxt = key ^ SIGN;
          st_nxt = ST_OK;
          idx_nxt = '0;
          pos_nxt = '0;
          did_down_nxt = 1'b0;
          if (op == OP_INSERT) begin
            if (count_r >= cnt_t'(HEAP_DEPTH)) begin
              st_nxt = ST_FULL;
              state_nxt = S_TOP_W;
            end else begin
              mreq.we = 1'b1;
              mreq.waddr = idx_t'(count_r);
              mreq.wdata = key ^ SIGN;
              pos_nxt = count_r;
              count_nxt = count_r + cnt_t'(1);
              state_nxt = S_SUP_W;
            end
          end else if (op == OP_DELETE || op == OP_SEARCH) begin
            if (count_r == '0) begin
              st_nxt = ST_EMPTY;
              state_nxt = S_TOP_W;
            end else begin
              mreq.re = 1'b1;
              mreq.raddr = '0;
              state_nxt = S_SCAN;
            end
          end else begin
            state_nxt = S_TOP_W;
          end
        end
      end
      S_SCAN: begin
        // rdata holds entry pos_r
        if (rdata == key_r) begin
          idx_nxt = idx_t'(pos_r);
          if (op_r == OP_SEARCH) begin
            state_nxt = S_TOP_W;
          end else begin
            count_nxt = count_r - cnt_t'(1);
            if (pos_r == count_r - cnt_t'(1)) begin
              state_nxt = S_TOP_W;
            end else begin
              mreq.re = 1'b1;
              mreq.raddr = idx_t'(count_r - cnt_t'(1));
              state_nxt = S_LASTW;
            end
          end
        end else if (pos_r + cnt_t'(1) >= count_r) begin
          st_nxt = ST_NOT_FOUND;
          state_nxt = S_TOP_W;
        end else begin
          pos_nxt = pos_r + cnt_t'(1);
          mreq.re = 1'b1;
          mreq.raddr = idx_t'(pos_r + cnt_t'(1));
        end
      end
      S_LASTW: begin
        // move last entry into the hole, then sift down
        key_nxt = rdata;
        mreq.we = 1'b1;
        mreq.waddr = idx_t'(pos_r);
        mreq.wdata = rdata;
        state_nxt = S_SDL_W;
      end
      S_SDL_W: begin
        if (lch >= count_r) begin
          state_nxt = S_SUP_W;
        end else begin
          mreq.re = 1'b1;
          mreq.raddr = idx_t'(lch);
          state_nxt = S_SDR_W;
        end
      end
      S_SDR_W: begin
        lval_nxt = rdata;
        if (rch < count_r) begin
          mreq.re = 1'b1;
          mreq.raddr = idx_t'(rch);
          state_nxt = S_SDR;
        end else if (key_r < rdata) begin
          mreq.we = 1'b1; mreq.waddr = idx_t'(pos_r); mreq.wdata = rdata;
          pos_nxt = lch; did_down_nxt = 1'b1;
          state_nxt = S_SDL_W;
        end else begin
          state_nxt = S_SUP_W;
        end
      end
      S_SDR: begin
        if (key_r < lval_r && !(lval_r < rdata)) begin
          mreq.we = 1'b1; mreq.waddr = idx_t'(pos_r); mreq.wdata = lval_r;
          pos_nxt = lch; did_down_nxt = 1'b1;
          state_nxt = S_SDL_W;
        end else if ((key_r < lval_r ? lval_r : key_r) < rdata) begin
          mreq.we = 1'b1; mreq.waddr = idx_t'(pos_r); mreq.wdata = rdata;
          pos_nxt = rch; did_down_nxt = 1'b1;
          state_nxt = S_SDL_W;
        end else begin
          state_nxt = S_SUP_W;
        end
      end
      S_SUP_W: begin
        // key_r sits at pos_r; moved down means no sift up needed
        if (pos_r == '0 || did_down_r) begin
          mreq.we = 1'b1; mreq.waddr = idx_t'(pos_r); mreq.wdata = key_r;
          state_nxt = S_TOP_W;
        end else begin
          mreq.re = 1'b1;
          mreq.raddr = idx_t'(par);
          state_nxt = S_SUP;
        end
      end
      S_SUP: begin
        if (rdata < key_r) begin
          mreq.we = 1'b1; mreq.waddr = idx_t'(pos_r); mreq.wdata = rdata;
          pos_nxt = par;
          state_nxt = S_SUP_W;
        end else begin
          mreq.we = 1'b1; mreq.waddr = idx_t'(pos_r); mreq.wdata = key_r;
          state_nxt = S_TOP_W;
        end
      end
      S_TOP_W: begin
        mreq.re = 1'b1;
        mreq.raddr = '0;
        state_nxt = S_TOP;
      end
      S_TOP: begin
        top_nxt = (count_r == '0) ? '0 : (rdata ^ SIGN);
        state_nxt = S_DONE;
      end
      S_DONE: begin
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign busy = (state_r != S_IDLE);
  assign done = (state_r == S_DONE);
  assign res_status = st_r;
  assign res_index = idx_r;
  assign res_count = count_r;
  assign res_top = top_r;
endmodule
`default_nettype wire

>>> rtl/max_heap_priority_table.sv
// Channel | Direction | Ports
// in      | request   | in_valid, in_ready, in_op, in_key_value
// out     | result    | out_valid, out_ready, out_status, out_found_index,
//         |           | out_entry_count, out_top_value
// One request at a time. Insert adds the entry and sifts it up; delete and
// search scan the store one entry a cycle (up to 1024), and delete then sifts
// the moved entry down or up. The single-port-read heap RAM sets the pace.
// Reset empties the heap; the store contents are not cleared.
// A finished result waits in the output register; the next request is taken
// once that result is accepted, at the earliest in the same cycle.
`default_nettype none
module max_heap_priority_table (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_valid,
  output logic              in_ready,
  input  wire logic [1:0]   in_op,
  input  wire logic signed [mhpt_pkg::KEY_WIDTH-1:0] in_key_value,
  output logic              out_valid,
  input  wire logic         out_ready,
  output logic [1:0]        out_status,
  output logic [mhpt_pkg::IDX_W-1:0] out_found_index,
  output logic [mhpt_pkg::CNT_W-1:0] out_entry_count,
  output logic signed [mhpt_pkg::KEY_WIDTH-1:0] out_top_value
);
  import mhpt_pkg::*;

  logic busy, done;
  logic [1:0] rs;
  idx_t ri;
  cnt_t rc;
  key_t rt, rdata;
  mem_req_t mreq;
  logic out_valid_r;

  mhpt_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(in_valid && in_ready), .op(in_op),
    .key(key_t'(in_key_value)), .busy(busy), .done(done),
    .res_status(rs), .res_index(ri), .res_count(rc), .res_top(rt),
    .mreq(mreq), .rdata(rdata)
  );

  mhpt_ram #(.WIDTH(KEY_WIDTH), .DEPTH(HEAP_DEPTH)) u_ram (
    .clk(clk), .we(mreq.we), .waddr(mreq.waddr), .wdata(mreq.wdata),
    .re(mreq.re), .raddr(mreq.raddr), .rdata(rdata)
  );

  // hold a new request off while an undelivered result would be overwritten
  assign in_ready = !busy && !(out_valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (done) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
    if (done) begin
      out_status <= rs;
      out_found_index <= ri;
      out_entry_count <= rc;
      out_top_value <= rt;
    end
  end
  assign out_valid = out_valid_r;

`ifndef SYNTHESIS
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !in_ready) else $error("request taken while busy");
  a_done_slot: assert property (@(posedge clk) disable iff (!rst_n)
    done |-> !(out_valid_r && !out_ready)) else $error("result overwritten");
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    rc <= cnt_t'(HEAP_DEPTH)) else $error("count out of range");
`endif
endmodule
`default_nettype wire
